/* rtl/core/osas_pkg.sv */
// Shared types and constants for the open-loop startup angle sequencer.
// No dependencies; every other file of the block imports this package.
package osas_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int RAMP_BITS  = 32;
    localparam int LOCK_BITS  = 16;
    localparam int RATE_BITS  = 16;
    localparam int SHIFT_BITS = 5;
    localparam int STEP_BITS  = 15;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;

    // Reset value of the error decay step, about 0.05 degree
    localparam logic [STEP_BITS-1:0] ERROR_STEP_RESET = STEP_BITS'(9);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LOCK_TICKS = 3'd0,
        REG_END_RAMP   = 3'd1,
        REG_RAMP_RATE  = 3'd2,
        REG_RAMP_SHIFT = 3'd3,
        REG_ERROR_STEP = 3'd4,
        REG_HOLD_OPEN  = 3'd5
    } cfg_reg_t;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic [LOCK_BITS-1:0]  lock_ticks;
        logic [RAMP_BITS-1:0]  end_ramp;
        logic [RATE_BITS-1:0]  ramp_rate;
        logic [SHIFT_BITS-1:0] ramp_shift;
        logic [STEP_BITS-1:0]  error_step;
        logic                  hold_open;
    } cfg_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle;
        logic                  closed_loop;
        logic                  mode_switched;
        logic [ANGLE_BITS-1:0] angle_error;
    } res_t;

endpackage

/* rtl/core/osas_in_if.sv */
// Input channel of the sequencer: one control tick or restart per transfer.
// Depends on osas_pkg for the angle width.
interface osas_in_if
    import osas_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic signed [ANGLE_BITS-1:0] est_angle;

    modport source (output valid, output command, output est_angle, input ready);
    modport sink   (input valid, input command, input est_angle, output ready);
endinterface

/* rtl/core/osas_out_if.sv */
// Result channel of the sequencer: one commutation angle per transfer.
// Depends on osas_pkg for the angle width.
interface osas_out_if
    import osas_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] angle;
    logic                         closed_loop;
    logic                         mode_switched;
    logic signed [ANGLE_BITS-1:0] angle_error;

    modport source (output valid, output angle, output closed_loop,
                    output mode_switched, output angle_error, input ready);
    modport sink   (input valid, input angle, input closed_loop,
                    input mode_switched, input angle_error, output ready);
endinterface

/* rtl/core/osas_cfg.sv */
// Configuration register bank of the sequencer, written through a plain write port.
// Depends on osas_pkg for the register codes and the cfg_t bundle.
module osas_cfg
    import osas_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    // Write the addressed register; ignore unused indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lock_ticks <= '0;
            cfg_reg.end_ramp   <= '0;
            cfg_reg.ramp_rate  <= '0;
            cfg_reg.ramp_shift <= '0;
            cfg_reg.error_step <= ERROR_STEP_RESET;
            cfg_reg.hold_open  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOCK_TICKS: cfg_reg.lock_ticks <= cfg_data[LOCK_BITS-1:0];
                REG_END_RAMP:   cfg_reg.end_ramp   <= cfg_data[RAMP_BITS-1:0];
                REG_RAMP_RATE:  cfg_reg.ramp_rate  <= cfg_data[RATE_BITS-1:0];
                REG_RAMP_SHIFT: cfg_reg.ramp_shift <= cfg_data[SHIFT_BITS-1:0];
                REG_ERROR_STEP: cfg_reg.error_step <= cfg_data[STEP_BITS-1:0];
                REG_HOLD_OPEN:  cfg_reg.hold_open  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/osas_engine.sv */
// Startup state and per-tick update: lock count, speed ramp, forced angle, error.
// Depends on osas_pkg for cfg_t, res_t and widths.
module osas_engine
    import osas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  step,
    input  logic                  command,
    input  logic [ANGLE_BITS-1:0] est_angle,
    output res_t                  res
);

    logic                  open_reg,   open_next;
    logic [LOCK_BITS-1:0]  lock_reg,   lock_next;
    logic [RAMP_BITS-1:0]  ramp_reg,   ramp_next;
    logic [ANGLE_BITS-1:0] forced_reg, forced_next;
    logic [ANGLE_BITS-1:0] err_reg,    err_next;

    logic [RAMP_BITS:0]    ramp_sum;
    logic [RAMP_BITS-1:0]  ramp_sat;
    logic signed [ANGLE_BITS:0] err_ext;
    logic signed [ANGLE_BITS:0] step_ext;
    logic signed [ANGLE_BITS:0] err_decay;
    logic                  switched;
    logic [ANGLE_BITS-1:0] ang;

    // Saturating ramp increment
    assign ramp_sum = {1'b0, ramp_reg} + (RAMP_BITS+1)'(cfg.ramp_rate);
    assign ramp_sat = ramp_sum[RAMP_BITS] ? '1 : ramp_sum[RAMP_BITS-1:0];

    // Move the error toward zero by one step, leave it once within a step
    assign err_ext  = {err_reg[ANGLE_BITS-1], err_reg};
    assign step_ext = (ANGLE_BITS+1)'({1'b0, cfg.error_step});
    always_comb
    begin
        if (err_ext > step_ext)
            err_decay = err_ext - step_ext;
        else if (err_ext < -step_ext)
            err_decay = err_ext + step_ext;
        else
            err_decay = err_ext;
    end

    // Next state and result of one tick
    always_comb
    begin
        open_next   = open_reg;
        lock_next   = lock_reg;
        ramp_next   = ramp_reg;
        err_next    = err_reg;
        forced_next = forced_reg;
        switched    = 1'b0;
        ang         = forced_reg;
        if (command == CMD_RESTART)
        begin
            open_next = 1'b1;
            lock_next = '0;
            ramp_next = '0;
        end
        else if (open_reg)
        begin
            if (lock_reg < cfg.lock_ticks)
                lock_next = lock_reg + 1'b1;
            else if (ramp_reg < cfg.end_ramp)
                ramp_next = ramp_sat;
            else
            begin
                err_next = forced_reg - est_angle;
                if (!cfg.hold_open)
                begin
                    open_next = 1'b0;
                    switched  = 1'b1;
                end
            end
            forced_next = forced_reg + ANGLE_BITS'(ramp_next >> cfg.ramp_shift);
            ang = open_next ? forced_next : est_angle + err_next;
        end
        else
        begin
            err_next = err_decay[ANGLE_BITS-1:0];
            ang      = est_angle + err_next;
        end
    end

    // Commit the state on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b1;
            lock_reg   <= '0;
            ramp_reg   <= '0;
            forced_reg <= '0;
            err_reg    <= '0;
        end
        else if (step)
        begin
            open_reg   <= open_next;
            lock_reg   <= lock_next;
            ramp_reg   <= ramp_next;
            forced_reg <= forced_next;
            err_reg    <= err_next;
        end
    end

    assign res.angle         = ang;
    assign res.closed_loop   = ~open_next;
    assign res.mode_switched = switched;
    assign res.angle_error   = err_next;

endmodule

/* rtl/core/open_loop_startup_angle_sequencer.sv */
// Open-loop startup angle sequencer, top level: input register, update, result register.
// Each input transfer loads the input register; the state update then feeds the result register,
// which holds its item while the output is stalled; one item per cycle sustained while the output
// accepts, set by the single state update between the input and result registers.
// Reset clears the pipeline valids and resets the startup state and the configuration registers.
// Depends on osas_pkg, osas_in_if, osas_out_if, osas_cfg and osas_engine.
module open_loop_startup_angle_sequencer
    import osas_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    osas_in_if.sink                  in_ch,
    osas_out_if.source               out_ch
);

    cfg_t cfg;
    res_t res;

    logic                  in_valid_reg;
    logic                  cmd_reg;
    logic [ANGLE_BITS-1:0] est_reg;
    logic                  out_valid_reg;
    res_t                  out_reg;
    logic                  advance;
    logic                  in_take;

    osas_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    osas_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (in_valid_reg && advance),
        .command   (cmd_reg),
        .est_angle (est_reg),
        .res       (res)
    );

    // Advance when the result register is free or being drained
    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_take     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !in_valid_reg || advance;

    // Hold the input item until the update stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= in_ch.command;
            est_reg <= in_ch.est_angle;
        end
    end

    // Result register: load on advance, drop after transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_reg <= res;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.angle         = out_reg.angle;
    assign out_ch.closed_loop   = out_reg.closed_loop;
    assign out_ch.mode_switched = out_reg.mode_switched;
    assign out_ch.angle_error   = out_reg.angle_error;

endmodule
